// File: src/qmc_pkg.sv
// ----------------------------------------------------------------------------
// qmc_pkg
// Shared types and constants for the qubit measurement block.
// ----------------------------------------------------------------------------
package qmc_pkg;
  localparam int QUBITS   = 10;
  localparam int AW       = 16;
  localparam int AFRAC    = AW - 1;
  localparam int NSTATES  = 1 << QUBITS;
  localparam int ACC_W    = 2 * AW + QUBITS;
  localparam int SQ_W     = 2 * AW;
  localparam int REC_W    = 3 * AFRAC + 1;
  localparam int ROOT_W   = (ACC_W + 1) / 2;
  localparam int REC_LO   = REC_W / 2;
  localparam int PP_W     = AW + 1 + REC_W - REC_LO;

  typedef logic [QUBITS-1:0] idx_t;
  typedef logic signed [AW-1:0] amp_t;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_MEASURE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    idx_t       amp_index;
    amp_t       write_re;
    amp_t       write_im;
    logic [3:0] qubit_sel;
    logic [15:0] rand_frac;
  } req_item_t;

  typedef struct packed {
    logic resp_kind;
    logic meas_bit;
    amp_t read_re;
    amp_t read_im;
  } resp_item_t;

  typedef enum logic [3:0] {
    CMD_IDLE, CMD_WRITE, CMD_READ, CMD_START, CMD_WALK, CMD_SUM,
    CMD_ROOT, CMD_SCALE, CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic first;
  } ctl_t;

  typedef struct packed {
    logic walk_done;
    logic sum_done;
    logic root_done;
    logic scale_done;
    logic rd_valid;
    logic clear_done;
  } sts_t;
endpackage

// File: src/qmc_if.sv
// ----------------------------------------------------------------------------
// qmc_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface qmc_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/qubit_measure_collapse.sv
// ----------------------------------------------------------------------------
// qubit_measure_collapse
// Stored state vector with projective single-qubit measurement.
// ----------------------------------------------------------------------------
// req channel: write (no response), read, or measure transfers.
// resp channel: one transfer per read or measure.
// A write passes through S_WRITE only; a read registers the address, reads the
// memory, latches the amplitude and then registers the response. A measure
// walks the 1024-entry amplitude memory three times at one entry per cycle
// (select, clear and sum, rescale), with 21 square-root steps and 46 divide
// steps between the second and third walk.
// One request is in flight at a time; req.ready stays low while a response
// waits, so a stalled receiver simply holds the block.
// Reset returns the sequencer to a clearing pass that zeroes the amplitude
// memory one entry per cycle; req.ready stays low until that pass ends,
// and resp.valid drops.
// ----------------------------------------------------------------------------
module qubit_measure_collapse (
  input logic   clk,
  input logic   rst,
  qmc_if.sink   req,
  qmc_if.source resp
);
  import qmc_pkg::*;

  ctl_t      ctl;
  sts_t      sts;
  req_item_t req_q;
  logic      meas_bit;
  amp_t      rd_re;
  amp_t      rd_im;

  qmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req(req), .resp(resp), .ctl(ctl), .req_q(req_q),
    .sts(sts), .meas_bit(meas_bit), .rd_re(rd_re), .rd_im(rd_im)
  );

  qmc_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req(req_q), .sts(sts),
    .meas_bit(meas_bit), .rd_re(rd_re), .rd_im(rd_im)
  );
endmodule

// File: src/qmc_datapath.sv
// ----------------------------------------------------------------------------
// qmc_datapath
// Amplitude memory, probability walk, square root / reciprocal, rescale.
// ----------------------------------------------------------------------------
module qmc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  qmc_pkg::ctl_t     ctl,
  input  qmc_pkg::req_item_t req,
  output qmc_pkg::sts_t     sts,
  output logic              meas_bit,
  output qmc_pkg::amp_t     rd_re,
  output qmc_pkg::amp_t     rd_im
);
  import qmc_pkg::*;

  logic [2*AW-1:0] mem [NSTATES];
  logic [2*AW-1:0] rdata;
  logic [QUBITS:0] rptr;
  logic [QUBITS:0] wptr;
  logic            rvld;
  idx_t            ridx_q;
  logic            we;
  idx_t            waddr;
  logic [2*AW-1:0] wdata;
  logic [ACC_W-1:0] cum;
  logic [ACC_W-1:0] target;
  idx_t            sel;
  logic            found;
  logic            bitv;
  logic [3:0]      q;
  logic [ACC_W-1:0] prob;
  logic [ACC_W-1:0] rv;
  logic [ACC_W-1:0] rres;
  logic [ACC_W-1:0] rbit;
  logic [REC_W:0]  rem;
  logic [REC_W-1:0] quot;
  logic [6:0]      step;
  logic            phase;
  logic            keep;
  logic signed [AW-1:0] a_re;
  logic signed [AW-1:0] a_im;
  logic [2*AW-1:0] sq;
  logic [ROOT_W-1:0] s_q;
  logic            sc_vld;
  logic            sc_last;
  idx_t            sc_idx;
  logic            sc_neg_re;
  logic            sc_neg_im;
  logic [PP_W-1:0] pp_re_hi;
  logic [PP_W-1:0] pp_re_lo;
  logic [PP_W-1:0] pp_im_hi;
  logic [PP_W-1:0] pp_im_lo;

  function automatic logic kbit(idx_t k, logic [3:0] qq);
    if (qq >= 4'(QUBITS)) return 1'b0;
    return k[qq[$clog2(QUBITS > 1 ? QUBITS : 2)-1:0]];
  endfunction

  function automatic logic [AW:0] amag(amp_t a);
    return a[AW-1] ? (AW+1)'(-$signed({a[AW-1], a})) : (AW+1)'({1'b0, a});
  endfunction

  function automatic amp_t round_sat(logic neg, logic [PP_W-1:0] hi,
                                     logic [PP_W-1:0] lo);
    logic [AW+REC_W:0]     p;
    logic [AW+REC_W:0]     pr;
    p  = ((AW+REC_W+1)'(hi) << REC_LO) + (AW+REC_W+1)'(lo);
    pr = (p + ((AW+REC_W+1)'(1) << (2*AFRAC-1))) >> (2*AFRAC);
    if (neg) begin
      if (pr > (AW+REC_W+1)'(1 << AFRAC)) return amp_t'(-(1 << AFRAC));
      return amp_t'(-pr[AW-1:0]);
    end
    if (pr > (AW+REC_W+1)'((1 << AFRAC) - 1)) return amp_t'((1 << AFRAC) - 1);
    return amp_t'(pr[AW-1:0]);
  endfunction

  assign a_re = rdata[2*AW-1:AW];
  assign a_im = rdata[AW-1:0];
  assign keep = kbit(ridx_q, q) == bitv;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[rptr[QUBITS-1:0]];
  end

  always_ff @(posedge clk) begin
    sq <= 32'($signed(a_re) * $signed(a_re)) + 32'($signed(a_im) * $signed(a_im));
  end

  always_comb begin
    we    = 1'b0;
    waddr = req.amp_index;
    wdata = {req.write_re, req.write_im};
    if (ctl.cmd == CMD_WRITE) we = 1'b1;
    else if (ctl.cmd == CMD_CLEAR && !rst) begin
      we = 1'b1; waddr = wptr[QUBITS-1:0]; wdata = '0;
    end else if (ctl.cmd == CMD_SUM && rvld && !keep) begin
      we = 1'b1; waddr = ridx_q; wdata = '0;
    end else if (ctl.cmd == CMD_SCALE && sc_vld) begin
      we = 1'b1; waddr = sc_idx;
      wdata = {round_sat(sc_neg_re, pp_re_hi, pp_re_lo),
               round_sat(sc_neg_im, pp_im_hi, pp_im_lo)};
    end
  end

  always_ff @(posedge clk) begin
    sts.rd_valid <= 1'b0;
    if (rst) begin
      rptr <= '0; rvld <= 1'b0; phase <= 1'b0; wptr <= '0;
      sc_vld <= 1'b0; sc_last <= 1'b0;
      sts.walk_done <= 1'b0; sts.sum_done <= 1'b0;
      sts.root_done <= 1'b0; sts.scale_done <= 1'b0;
      sts.clear_done <= 1'b0;
    end else begin
      sts.walk_done <= 1'b0; sts.sum_done <= 1'b0;
      sts.root_done <= 1'b0; sts.scale_done <= 1'b0;
      sts.clear_done <= 1'b0;
      unique case (ctl.cmd)
        CMD_CLEAR: begin
          wptr <= wptr + 1'b1;
          if (wptr == (QUBITS+1)'(NSTATES-1)) sts.clear_done <= 1'b1;
        end
        CMD_READ: begin
          if (ctl.first) begin
            rptr <= {1'b0, req.amp_index}; phase <= 1'b0;
          end else if (!phase) phase <= 1'b1;
          else begin
            rd_re <= a_re; rd_im <= a_im; sts.rd_valid <= 1'b1;
          end
        end
        CMD_START: begin
          q      <= req.qubit_sel;
          target <= ACC_W'(req.rand_frac) << (2*AFRAC-16);
          cum <= '0; found <= 1'b0; sel <= idx_t'(NSTATES-1);
          rptr <= '0; rvld <= 1'b0; wptr <= '0; phase <= 1'b0;
        end
        CMD_WALK: begin
          // two-stage pipe: addr -> rdata -> sq
          if (rptr < (QUBITS+1)'(NSTATES)) rptr <= rptr + 1'b1;
          ridx_q <= rptr[QUBITS-1:0];
          rvld   <= rptr < (QUBITS+1)'(NSTATES);
          phase  <= rvld;
          if (phase) begin
            if (!found && (cum + ACC_W'(sq)) >= target) begin
              found <= 1'b1; sel <= idx_t'(wptr);
            end
            cum  <= cum + ACC_W'(sq);
            wptr <= wptr + 1'b1;
            if (wptr == (QUBITS+1)'(NSTATES-1)) sts.walk_done <= 1'b1;
          end
          if (ctl.first) begin
            rptr <= '0; rvld <= 1'b0; phase <= 1'b0; wptr <= '0;
          end
        end
        CMD_SUM: begin
          if (ctl.first) begin
            bitv <= (target == '0) ? kbit('0, q) : kbit(sel, q);
            meas_bit <= (target == '0) ? kbit('0, q) : kbit(sel, q);
            rptr <= '0; rvld <= 1'b0; phase <= 1'b0; wptr <= '0; prob <= '0;
          end else begin
            if (rptr < (QUBITS+1)'(NSTATES)) rptr <= rptr + 1'b1;
            ridx_q <= rptr[QUBITS-1:0];
            rvld   <= rptr < (QUBITS+1)'(NSTATES);
            phase  <= rvld && keep;
            if (phase) prob <= prob + ACC_W'(sq);
            if (rvld && ridx_q == idx_t'(NSTATES-1)) wptr <= (QUBITS+1)'(1);
            if (wptr[0]) sts.sum_done <= 1'b1;
          end
        end
        CMD_ROOT: begin
          if (ctl.first) begin
            rv <= prob; rres <= '0; rbit <= ACC_W'(1) << (2*((ACC_W-1)/2));
            step <= '0; phase <= 1'b0;
          end else if (!phase) begin
            if (rbit != '0) begin
              if (rv >= rres + rbit) begin
                rv <= rv - (rres + rbit); rres <= (rres >> 1) + rbit;
              end else rres <= rres >> 1;
              rbit <= rbit >> 2;
            end else begin
              phase <= 1'b1; s_q <= ROOT_W'(rres);
              rem <= '0; quot <= '0; step <= 7'(REC_W);
            end
          end else if (s_q == '0) begin
            sts.root_done <= 1'b1; quot <= '0;
          end else if (step != '0) begin
            // restoring divide of 2^(3*AFRAC) by s
            if ({rem[REC_W-1:0], (step == 7'(REC_W))} >= (REC_W+1)'(s_q)) begin
              rem  <= {rem[REC_W-1:0], (step == 7'(REC_W))} - (REC_W+1)'(s_q);
              quot <= {quot[REC_W-2:0], 1'b1};
            end else begin
              rem  <= {rem[REC_W-1:0], (step == 7'(REC_W))};
              quot <= {quot[REC_W-2:0], 1'b0};
            end
            step <= step - 1'b1;
          end else sts.root_done <= 1'b1;
        end
        CMD_SCALE: begin
          if (ctl.first) begin
            rptr <= '0; rvld <= 1'b0; wptr <= '0; sc_vld <= 1'b0; sc_last <= 1'b0;
          end else begin
            // addr -> rdata -> partial products -> rounded write
            if (rptr < (QUBITS+1)'(NSTATES)) rptr <= rptr + 1'b1;
            ridx_q <= rptr[QUBITS-1:0];
            rvld   <= rptr < (QUBITS+1)'(NSTATES);
            sc_vld    <= rvld && keep;
            sc_last   <= rvld && ridx_q == idx_t'(NSTATES-1);
            sc_idx    <= ridx_q;
            sc_neg_re <= a_re[AW-1];
            sc_neg_im <= a_im[AW-1];
            pp_re_hi  <= PP_W'(amag(a_re) * quot[REC_W-1:REC_LO]);
            pp_re_lo  <= PP_W'(amag(a_re) * quot[REC_LO-1:0]);
            pp_im_hi  <= PP_W'(amag(a_im) * quot[REC_W-1:REC_LO]);
            pp_im_lo  <= PP_W'(amag(a_im) * quot[REC_LO-1:0]);
            if (sc_last) sts.scale_done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/qmc_ctrl.sv
// ----------------------------------------------------------------------------
// qmc_ctrl
// Sequencer: accepts requests, steps datapath phases, issues responses.
// ----------------------------------------------------------------------------
module qmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  qmc_if.sink                 req,
  qmc_if.source               resp,
  output qmc_pkg::ctl_t       ctl,
  output qmc_pkg::req_item_t  req_q,
  input  qmc_pkg::sts_t       sts,
  input  logic                meas_bit,
  input  qmc_pkg::amp_t       rd_re,
  input  qmc_pkg::amp_t       rd_im
);
  import qmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_READ, S_START, S_WALK, S_SUM, S_ROOT, S_SCALE, S_OUT,
    S_CLEAR
  } state_t;

  state_t state;
  logic   first;

  assign req.ready = (state == S_IDLE) && !resp.valid;
  always_comb begin
    ctl.first = first;
    unique case (state)
      S_CLEAR: ctl.cmd = CMD_CLEAR;
      S_WRITE: ctl.cmd = CMD_WRITE;
      S_READ:  ctl.cmd = CMD_READ;
      S_START: ctl.cmd = CMD_START;
      S_WALK:  ctl.cmd = CMD_WALK;
      S_SUM:   ctl.cmd = CMD_SUM;
      S_ROOT:  ctl.cmd = CMD_ROOT;
      S_SCALE: ctl.cmd = CMD_SCALE;
      default: ctl.cmd = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; first <= 1'b0; resp.valid <= 1'b0;
    end else begin
      first <= 1'b0;
      if (resp.valid && resp.ready) resp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (sts.clear_done) state <= S_IDLE;
        S_IDLE: if (req.valid && req.ready) begin
          req_q <= req.data; first <= 1'b1;
          unique case (req_t'(req.data.req_type))
            REQ_WRITE:   state <= S_WRITE;
            REQ_MEASURE: state <= S_START;
            REQ_READ:    state <= S_READ;
            default:     state <= S_IDLE;
          endcase
        end
        S_WRITE: state <= S_IDLE;
        S_READ: if (sts.rd_valid) begin
          resp.data <= '{resp_kind: 1'b1, meas_bit: 1'b0, read_re: rd_re, read_im: rd_im};
          resp.valid <= 1'b1; state <= S_IDLE;
        end
        S_START: begin state <= S_WALK; first <= 1'b1; end
        S_WALK: if (sts.walk_done) begin state <= S_SUM; first <= 1'b1; end
        S_SUM: if (sts.sum_done) begin state <= S_ROOT; first <= 1'b1; end
        S_ROOT: if (sts.root_done) begin state <= S_SCALE; first <= 1'b1; end
        S_SCALE: if (sts.scale_done) state <= S_OUT;
        S_OUT: begin
          resp.data <= '{resp_kind: 1'b0, meas_bit: meas_bit, read_re: '0, read_im: '0};
          resp.valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/sv/tb_qubit_measure_collapse.sv
// ----------------------------------------------------------------------------
// tb_qubit_measure_collapse
// Self-checking bench: writes, reads and measures a full state vector and
// checks each response against a fixed-point state-vector predictor.
// ----------------------------------------------------------------------------
module tb_qubit_measure_collapse;
  import qmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 4000000;
  localparam int AMAX = 32767;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qmc_if #(.T(req_item_t))  req (.clk(clk));
  qmc_if #(.T(resp_item_t)) resp (.clk(clk));

  qubit_measure_collapse u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .resp(resp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_item_t  pending_q[$];
  resp_item_t outcome_q[$];
  int         amp_re[NSTATES];
  int         amp_im[NSTATES];
  int         src_idle_pct;
  int         snk_stall_pct;
  bit         hold_src;
  int         errors;
  int         cycles;

  function automatic void enqueue(req_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic longint mag_sq(int k);
    return longint'(amp_re[k]) * amp_re[k] + longint'(amp_im[k]) * amp_im[k];
  endfunction

  function automatic longint isqrt(longint v);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic int rescale(int a, longint r);
    longint m;
    longint p;
    m = (a < 0) ? -longint'(a) : longint'(a);
    p = (m * r + (longint'(1) << 29)) >>> 30;
    if (a < 0) return (p > AMAX + 1) ? -AMAX - 1 : -int'(p);
    return (p > AMAX) ? AMAX : int'(p);
  endfunction

  function automatic logic collapse_qubit(int q, int rnd);
    longint target;
    longint cum;
    longint prob;
    longint r;
    int sel;
    logic b;
    target = longint'(rnd) << 14;
    sel = NSTATES - 1;
    cum = 0;
    prob = 0;
    if (target == 0) begin
      sel = 0;
    end else begin
      for (int k = 0; k < NSTATES; k++) begin
        cum += mag_sq(k);
        if (cum >= target) begin
          sel = k;
          break;
        end
      end
    end
    b = (q < QUBITS) ? sel[q] : 1'b0;
    for (int k = 0; k < NSTATES; k++) begin
      if (((q < QUBITS) ? k[q] : 1'b0) == b) begin
        prob += mag_sq(k);
      end else begin
        amp_re[k] = 0;
        amp_im[k] = 0;
      end
    end
    r = isqrt(prob);
    if (r == 0) return b;
    r = (longint'(1) << 45) / r;
    for (int k = 0; k < NSTATES; k++) begin
      if (((q < QUBITS) ? k[q] : 1'b0) == b) begin
        amp_re[k] = rescale(amp_re[k], r);
        amp_im[k] = rescale(amp_im[k], r);
      end
    end
    return b;
  endfunction

  task automatic predict(req_item_t it);
    resp_item_t o;
    o = '0;
    case (req_t'(it.req_type))
      REQ_WRITE: begin
        amp_re[it.amp_index] = it.write_re;
        amp_im[it.amp_index] = it.write_im;
      end
      REQ_MEASURE: begin
        o.meas_bit = collapse_qubit(it.qubit_sel, it.rand_frac);
        outcome_q.insert(outcome_q.size(), o);
      end
      REQ_READ: begin
        o.resp_kind = 1'b1;
        o.read_re = amp_t'(amp_re[it.amp_index]);
        o.read_im = amp_t'(amp_im[it.amp_index]);
        outcome_q.insert(outcome_q.size(), o);
      end
      default: ;
    endcase
  endtask

  function automatic req_item_t mk(req_t t, int idx, int re, int im, int q, int rnd);
    req_item_t it;
    it.req_type = t;
    it.amp_index = idx_t'(idx);
    it.write_re = amp_t'(re);
    it.write_im = amp_t'(im);
    it.qubit_sel = 4'(q);
    it.rand_frac = 16'(rnd);
    return it;
  endfunction

  // nz random entries written on top of the current vector
  task automatic load_vector(int nz, bit big);
    int a;
    a = big ? 16383 : 32767 / (nz + 1);
    for (int i = 0; i < nz; i++) begin
      enqueue(mk(REQ_WRITE, $urandom_range(NSTATES - 1),
        $urandom_range(2 * a) - a, $urandom_range(2 * a) - a, 0, 0));
    end
  endtask

  task automatic rand_ops(int n);
    int t;
    for (int i = 0; i < n; i++) begin
      t = $urandom_range(99);
      if (t < 40)
        enqueue(mk(REQ_WRITE, $urandom, $urandom, $urandom, 0, 0));
      else if (t < 70)
        enqueue(mk(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom));
      else if (t < 95)
        enqueue(mk(REQ_MEASURE, $urandom, $urandom, $urandom,
          $urandom_range(11), (t < 73) ? 0 : $urandom));
      else
        enqueue(mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || req.valid || outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data <= '0;
    end else if (!req.valid || req.ready) begin
      if (pending_q.size() != 0 && !hold_src && $urandom_range(99) >= src_idle_pct) begin
        req.valid <= 1'b1;
        req.data <= pending_q.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) predict(req.data);
  end

  always @(posedge clk) begin
    resp_item_t exp_o;
    if (rst) begin
      resp.ready <= 1'b0;
    end else begin
      resp.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (resp.valid && resp.ready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: %p", resp.data);
        end else begin
          exp_o = outcome_q.pop_front();
          if (resp.data !== exp_o) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp_o, resp.data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    resp.ready = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_src = 1'b0;
    errors = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, all ops, special cases
    load_vector(4, 1'b0);
    enqueue(mk(REQ_WRITE, 0, -32768, 32767, 0, 0));
    enqueue(mk(REQ_WRITE, 1023, 32767, -32768, 0, 0));
    enqueue(mk(REQ_READ, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_READ, 1023, 0, 0, 0, 0));
    enqueue(mk(REQ_NONE, 5, 1, 1, 1, 1));
    enqueue(mk(REQ_MEASURE, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_MEASURE, 0, 0, 0, 9, 65535));
    enqueue(mk(REQ_MEASURE, 0, 0, 0, 15, 30000));
    enqueue(mk(REQ_READ, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_READ, 1023, 0, 0, 0, 0));
    enqueue(mk(REQ_WRITE, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_WRITE, 1023, 0, 0, 0, 0));
    enqueue(mk(REQ_MEASURE, 0, 0, 0, 3, 40000));
    enqueue(mk(REQ_READ, 0, 0, 0, 0, 0));
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 81) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 81) : 0;
      load_vector($urandom_range(1, 8), ph[0]);
      rand_ops(40);
      if (ph == 1) begin
        while (pending_q.size() > 20) @(posedge clk);
        hold_src = 1'b1;
        while (req.valid || outcome_q.size() != 0) @(posedge clk);
        hold_src = 1'b0;
      end
      wait_drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: qubit_measure_collapse.f
src/qmc_pkg.sv
src/qmc_if.sv
src/qmc_datapath.sv
src/qmc_ctrl.sv
src/qubit_measure_collapse.sv
tb/sv/tb_qubit_measure_collapse.sv
